// ----- hdl/melody_note_sequencer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the melody note sequencer
// Clocked property wrappers with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef MELODY_NOTE_SEQUENCER_CORE_ASSERT_SVH
`define MELODY_NOTE_SEQUENCER_CORE_ASSERT_SVH

// plain property, checked at every edge outside reset
`define MSQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property on the cycle after a condition
`define MSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/msq_pkg.sv -----
// ----------------------------------------------------------------------------
// Melody note sequencer package
// Field widths, codes, register defaults and shared types.
// ----------------------------------------------------------------------------
package msq_pkg;

   localparam int SONG_SLOTS_DEF     = 16;
   localparam int NOTES_PER_SONG_DEF = 32;

   localparam int MODE_W    = 2;
   localparam int KEY_W     = 4;
   localparam int SONG_W    = 4;
   localparam int POS_W     = 5;
   localparam int FREQ_W    = 12;
   localparam int DUR_W     = 8;
   localparam int STATE_W   = 2;
   localparam int PERIOD_W  = 16;
   localparam int COMPARE_W = 15;
   localparam int TICK_W    = 9;
   localparam int COUNT_W   = 4;
   localparam int TCLK_W    = 20;
   localparam int GATE_W    = 7;
   localparam int PROD_W    = DUR_W + GATE_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_KEY  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOAD = 2'd2;

   typedef enum logic [STATE_W-1:0] {
      PS_SELECT = 2'd0,
      PS_PLAY   = 2'd1,
      PS_PAUSE  = 2'd2
   } play_state_type;

   localparam logic [KEY_W-1:0] START_KEY = 4'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_SONG_COUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TONE_CLOCK   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_PERCENT = 2'd2;

   localparam logic [COUNT_W-1:0] SONG_COUNT_RST   = 4'd9;
   localparam logic [TCLK_W-1:0]  TONE_CLOCK_RST   = 20'd250000;
   localparam logic [GATE_W-1:0]  GATE_PERCENT_RST = 7'd85;

   localparam int GATE_DIV  = 100;
   localparam int DIV_STEPS = TCLK_W;

   typedef struct packed {
      logic              last;
      logic [DUR_W-1:0]  duration;
      logic [FREQ_W-1:0] freq;
   } note_type;

   typedef struct packed {
      logic              start;
      logic [TCLK_W-1:0] dividend;
      logic [FREQ_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [TCLK_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- hdl/msq_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying tick, key and note load items.
// ----------------------------------------------------------------------------
interface msq_req_if;
   logic                         valid;
   logic                         ready;
   logic [msq_pkg::MODE_W-1:0]   mode;
   logic [msq_pkg::KEY_W-1:0]    key;
   logic [msq_pkg::SONG_W-1:0]   load_song;
   logic [msq_pkg::POS_W-1:0]    load_position;
   logic [msq_pkg::FREQ_W-1:0]   load_freq;
   logic [msq_pkg::DUR_W-1:0]    load_duration;
   logic                         load_last;

   modport source (
      output valid, mode, key, load_song, load_position, load_freq, load_duration,
             load_last,
      input  ready
   );

   modport sink (
      input  valid, mode, key, load_song, load_position, load_freq, load_duration,
             load_last,
      output ready
   );
endinterface

// ----- hdl/msq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the player status after each item.
// ----------------------------------------------------------------------------
interface msq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [msq_pkg::STATE_W-1:0]     play_state;
   logic [msq_pkg::SONG_W-1:0]      song_select;
   logic [msq_pkg::POS_W-1:0]       note_pos;
   logic [msq_pkg::PERIOD_W-1:0]    tone_period;
   logic [msq_pkg::COMPARE_W-1:0]   tone_compare;
   logic                            display_refresh;

   modport source (
      output valid, play_state, song_select, note_pos, tone_period, tone_compare,
             display_refresh,
      input  ready
   );

   modport sink (
      input  valid, play_state, song_select, note_pos, tone_period, tone_compare,
             display_refresh,
      output ready
   );
endinterface

// ----- hdl/msq_divider.sv -----
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle, for the tone period.
// ----------------------------------------------------------------------------
module msq_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  msq_pkg::div_req_type div_req,
   output msq_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(msq_pkg::DIV_STEPS);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [msq_pkg::TCLK_W-1:0]    quo_ff, quo_in;
   logic [msq_pkg::FREQ_W-1:0]    rem_ff, rem_in;
   logic [msq_pkg::FREQ_W-1:0]    dvs_ff, dvs_in;

   logic [msq_pkg::FREQ_W:0]      shifted;
   logic [msq_pkg::FREQ_W:0]      diff;
   logic                          fits;

   assign shifted = {rem_ff, quo_ff[msq_pkg::TCLK_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where the divisor fits
         quo_in = {quo_ff[msq_pkg::TCLK_W-2:0], fits};
         rem_in = fits ? diff[msq_pkg::FREQ_W-1:0] : shifted[msq_pkg::FREQ_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(msq_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- hdl/msq_note_store.sv -----
// ----------------------------------------------------------------------------
// Note store
// Single write port, single registered read port note memory.
// ----------------------------------------------------------------------------
module msq_note_store #(
   parameter int DEPTH = msq_pkg::SONG_SLOTS_DEF * msq_pkg::NOTES_PER_SONG_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  msq_pkg::note_type        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output msq_pkg::note_type        rd_data
);

   msq_pkg::note_type mem [DEPTH];
   msq_pkg::note_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/melody_note_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Melody note sequencer core
// Plays songs from a note store: key handling, tick timing, tone programming.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  req_if   | in        | tick, key or note load item (valid/ready)
//  rsp_if   | out       | player status, one per request item (valid/ready)
//  csr_*    | in        | register write: song_count, tone_clock, gate_percent
//
//  Result after the transfer: loads, idle items and keys that set no tone go
//  straight to S_RESULT; a start or resume goes through S_FETCH and S_USE; a tick
//  goes through S_FETCH, S_USE and S_TICK, and a tick onto a new note then through
//  S_FETCH and S_USE again. A sounding note adds S_DIVIDE, the 20-step serial
//  divider for tone_clock/freq. One item at a time; synchronous active-high reset,
//  note store not cleared. A stalled result waits in the output register.
// ----------------------------------------------------------------------------
module melody_note_sequencer_core #(
   parameter int SONG_SLOTS     = msq_pkg::SONG_SLOTS_DEF,
   parameter int NOTES_PER_SONG = msq_pkg::NOTES_PER_SONG_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   msq_req_if.sink                            req_if,
   msq_rsp_if.source                          rsp_if,
   input  logic                               csr_write_en,
   input  logic [msq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [msq_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DEPTH  = SONG_SLOTS * NOTES_PER_SONG;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CUR_W  = $clog2(NOTES_PER_SONG);
   localparam int LPOS_W = (CUR_W + 1 > msq_pkg::POS_W) ? CUR_W + 1 : msq_pkg::POS_W;
   localparam logic [msq_pkg::SONG_W:0] SLOTS_L = (msq_pkg::SONG_W + 1)'(SONG_SLOTS);
   localparam logic [CUR_W:0]           NPS_L   = (CUR_W + 1)'(NOTES_PER_SONG);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_USE,
      S_TICK,
      S_DIVIDE,
      S_RESULT
   } seq_state_type;

   seq_state_type                      state_ff, state_in;
   msq_pkg::play_state_type            mode_ff, mode_in;
   logic [msq_pkg::SONG_W-1:0]         sel_ff, sel_in;
   logic [CUR_W-1:0]                   cur_ff, cur_in;
   logic [msq_pkg::TICK_W-1:0]         tick_ff, tick_in;
   logic [msq_pkg::PERIOD_W-1:0]       period_ff, period_in;
   logic [msq_pkg::COMPARE_W-1:0]      compare_ff, compare_in;
   logic                               refresh_ff, refresh_in;
   logic                               fetch_tick_ff, fetch_tick_in;
   logic [msq_pkg::PROD_W-1:0]         prod_ff, prod_in;

   logic [msq_pkg::COUNT_W-1:0]        song_count_ff, song_count_in;
   logic [msq_pkg::TCLK_W-1:0]         tone_clock_ff, tone_clock_in;
   logic [msq_pkg::GATE_W-1:0]         gate_pct_ff, gate_pct_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [msq_pkg::STATE_W-1:0]        rsp_state_ff, rsp_state_in;
   logic [msq_pkg::SONG_W-1:0]         rsp_song_ff, rsp_song_in;
   logic [msq_pkg::POS_W-1:0]          rsp_pos_ff, rsp_pos_in;
   logic [msq_pkg::PERIOD_W-1:0]       rsp_period_ff, rsp_period_in;
   logic [msq_pkg::COMPARE_W-1:0]      rsp_compare_ff, rsp_compare_in;
   logic                               rsp_refresh_ff, rsp_refresh_in;

   logic                               req_xfer;
   logic [msq_pkg::KEY_W-1:0]          key_m1;
   logic                               key_song;
   logic                               key_slot_ok;
   logic                               load_ok;
   logic [CUR_W:0]                     cur_inc;
   logic [msq_pkg::PERIOD_W-1:0]       tick_scaled;
   logic [msq_pkg::PERIOD_W-1:0]       prod_wide;
   logic                               gate_hit;
   logic [msq_pkg::PERIOD_W-1:0]       period_new;

   logic                               wr_en;
   logic [ADDR_W-1:0]                  wr_addr;
   msq_pkg::note_type                  wr_data;
   logic                               rd_en;
   logic [ADDR_W-1:0]                  rd_addr;
   msq_pkg::note_type                  note_rd;

   msq_pkg::div_req_type               div_req;
   msq_pkg::div_rsp_type               div_rsp;

   msq_note_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (note_rd)
   );

   msq_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_xfer    = req_if.valid && req_if.ready;
   assign key_m1      = req_if.key - 4'd1;
   assign key_song    = (req_if.key != 4'd0) && (req_if.key <= song_count_ff);
   assign key_slot_ok = ({1'b0, key_m1} < SLOTS_L);
   assign load_ok     = ({1'b0, req_if.load_song} < SLOTS_L) &&
                        (LPOS_W'(req_if.load_position) < LPOS_W'(NOTES_PER_SONG));

   assign wr_addr = ADDR_W'(32'(req_if.load_song) * NOTES_PER_SONG +
                            32'(req_if.load_position));
   assign wr_data = '{last:     req_if.load_last,
                      duration: req_if.load_duration,
                      freq:     req_if.load_freq};
   assign rd_addr = ADDR_W'(32'(sel_ff) * NOTES_PER_SONG + 32'(cur_ff));

   assign cur_inc = {1'b0, cur_ff} + 1'b1;

   // silence point: tick == floor(prod/100) <=> tick*100 <= prod < tick*100+100
   assign tick_scaled = msq_pkg::PERIOD_W'(tick_ff) * msq_pkg::PERIOD_W'(msq_pkg::GATE_DIV);
   assign prod_wide   = msq_pkg::PERIOD_W'(prod_ff);
   assign gate_hit    = (tick_scaled <= prod_wide) &&
                        (prod_wide < tick_scaled + msq_pkg::PERIOD_W'(msq_pkg::GATE_DIV));

   // period = quotient - 1, clamped at zero and at the 16-bit ceiling
   always_comb begin
      if (div_rsp.quotient == '0) begin
         period_new = '0;
      end else if (div_rsp.quotient > msq_pkg::TCLK_W'(32'h1_0000)) begin
         period_new = '1;
      end else begin
         period_new = msq_pkg::PERIOD_W'(div_rsp.quotient - 1'b1);
      end
   end

   always_comb begin
      state_in         = state_ff;
      mode_in          = mode_ff;
      sel_in           = sel_ff;
      cur_in           = cur_ff;
      tick_in          = tick_ff;
      period_in        = period_ff;
      compare_in       = compare_ff;
      refresh_in       = refresh_ff;
      fetch_tick_in    = fetch_tick_ff;
      prod_in          = prod_ff;
      song_count_in    = song_count_ff;
      tone_clock_in    = tone_clock_ff;
      gate_pct_in      = gate_pct_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_state_in     = rsp_state_ff;
      rsp_song_in      = rsp_song_ff;
      rsp_pos_in       = rsp_pos_ff;
      rsp_period_in    = rsp_period_ff;
      rsp_compare_in   = rsp_compare_ff;
      rsp_refresh_in   = rsp_refresh_ff;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = tone_clock_ff;
      div_req.divisor  = note_rd.freq;

      if (csr_write_en) begin
         case (csr_index)
            msq_pkg::CSR_SONG_COUNT:   song_count_in = csr_wdata[msq_pkg::COUNT_W-1:0];
            msq_pkg::CSR_TONE_CLOCK:   tone_clock_in = csr_wdata[msq_pkg::TCLK_W-1:0];
            msq_pkg::CSR_GATE_PERCENT: gate_pct_in   = csr_wdata[msq_pkg::GATE_W-1:0];
            default: ;
         endcase
      end

      // drop the result once transferred
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               refresh_in = 1'b0;
               state_in   = S_RESULT;
               case (req_if.mode)
                  msq_pkg::MODE_LOAD: begin
                     wr_en = load_ok;
                  end
                  msq_pkg::MODE_KEY: begin
                     refresh_in = 1'b1;
                     case (mode_ff)
                        msq_pkg::PS_SELECT: begin
                           if (key_song) begin
                              if (key_slot_ok) begin
                                 sel_in = key_m1;
                              end
                           end else if (req_if.key == msq_pkg::START_KEY) begin
                              cur_in        = '0;
                              tick_in       = '0;
                              mode_in       = msq_pkg::PS_PLAY;
                              fetch_tick_in = 1'b0;
                              state_in      = S_FETCH;
                           end
                        end
                        msq_pkg::PS_PLAY: begin
                           if (req_if.key == msq_pkg::START_KEY) begin
                              mode_in    = msq_pkg::PS_PAUSE;
                              compare_in = '0;
                           end
                        end
                        default: begin
                           if (req_if.key == msq_pkg::START_KEY) begin
                              mode_in       = msq_pkg::PS_PLAY;
                              fetch_tick_in = 1'b0;
                              state_in      = S_FETCH;
                           end
                        end
                     endcase
                  end
                  msq_pkg::MODE_TICK: begin
                     if (mode_ff == msq_pkg::PS_PLAY) begin
                        fetch_tick_in = 1'b1;
                        state_in      = S_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            rd_en    = 1'b1;
            state_in = S_USE;
         end
         S_USE: begin
            if (fetch_tick_ff) begin
               prod_in  = msq_pkg::PROD_W'(note_rd.duration) * msq_pkg::PROD_W'(gate_pct_ff);
               tick_in  = tick_ff + 1'b1;
               state_in = S_TICK;
            end else if (note_rd.freq == '0) begin
               // rest: silence, keep the period
               compare_in = '0;
               state_in   = S_RESULT;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIVIDE;
            end
         end
         S_TICK: begin
            if (gate_hit) begin
               compare_in = '0;
            end
            state_in = S_RESULT;
            if (tick_ff >= {1'b0, note_rd.duration}) begin
               tick_in = '0;
               if (note_rd.last || (cur_inc >= NPS_L)) begin
                  cur_in     = '0;
                  mode_in    = msq_pkg::PS_SELECT;
                  refresh_in = 1'b1;
               end else begin
                  cur_in        = cur_inc[CUR_W-1:0];
                  fetch_tick_in = 1'b0;
                  state_in      = S_FETCH;
               end
            end
         end
         S_DIVIDE: begin
            if (div_rsp.done) begin
               period_in  = period_new;
               compare_in = period_new[msq_pkg::PERIOD_W-1:1];
               state_in   = S_RESULT;
            end
         end
         S_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_state_in   = mode_ff;
               rsp_song_in    = sel_ff;
               rsp_pos_in     = msq_pkg::POS_W'(cur_ff);
               rsp_period_in  = period_ff;
               rsp_compare_in = compare_ff;
               rsp_refresh_in = refresh_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= msq_pkg::PS_SELECT;
         sel_ff        <= '0;
         cur_ff        <= '0;
         tick_ff       <= '0;
         period_ff     <= '0;
         compare_ff    <= '0;
         song_count_ff <= msq_pkg::SONG_COUNT_RST;
         tone_clock_ff <= msq_pkg::TONE_CLOCK_RST;
         gate_pct_ff   <= msq_pkg::GATE_PERCENT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         sel_ff        <= sel_in;
         cur_ff        <= cur_in;
         tick_ff       <= tick_in;
         period_ff     <= period_in;
         compare_ff    <= compare_in;
         song_count_ff <= song_count_in;
         tone_clock_ff <= tone_clock_in;
         gate_pct_ff   <= gate_pct_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      refresh_ff     <= refresh_in;
      fetch_tick_ff  <= fetch_tick_in;
      prod_ff        <= prod_in;
      rsp_state_ff   <= rsp_state_in;
      rsp_song_ff    <= rsp_song_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_period_ff  <= rsp_period_in;
      rsp_compare_ff <= rsp_compare_in;
      rsp_refresh_ff <= rsp_refresh_in;
   end

   assign req_if.ready           = (state_ff == S_IDLE);
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.play_state      = rsp_state_ff;
   assign rsp_if.song_select     = rsp_song_ff;
   assign rsp_if.note_pos        = rsp_pos_ff;
   assign rsp_if.tone_period     = rsp_period_ff;
   assign rsp_if.tone_compare    = rsp_compare_ff;
   assign rsp_if.display_refresh = rsp_refresh_ff;

endmodule

// ----- hdl/msq_checker.sv -----
// ----------------------------------------------------------------------------
// Melody note sequencer port checker
// Port-level properties, bound to the core.
// ----------------------------------------------------------------------------
`include "melody_note_sequencer_core_assert.svh"

module msq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [msq_pkg::STATE_W-1:0]       rsp_play_state,
   input logic [msq_pkg::SONG_W-1:0]        rsp_song_select,
   input logic [msq_pkg::POS_W-1:0]         rsp_note_pos,
   input logic [msq_pkg::PERIOD_W-1:0]      rsp_tone_period,
   input logic [msq_pkg::COMPARE_W-1:0]     rsp_tone_compare,
   input logic                              rsp_display_refresh
);

   // a stalled result holds its payload
   `MSQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_play_state) && $stable(rsp_song_select) && $stable(rsp_note_pos) && $stable(rsp_tone_period) && $stable(rsp_tone_compare) && $stable(rsp_display_refresh), "result changed while stalled")

   // one item at a time: busy right after a transfer
   `MSQ_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while an item is in work")

   // paused means silent
   `MSQ_ASSERT(a_pause_silent, clock, reset, !(rsp_valid && (rsp_play_state == msq_pkg::PS_PAUSE)) || (rsp_tone_compare == '0), "tone sounding while paused")

   // compare is either off or half the programmed period
   `MSQ_ASSERT(a_compare_half, clock, reset, !rsp_valid || (rsp_tone_compare == '0) || (rsp_tone_compare == rsp_tone_period[msq_pkg::PERIOD_W-1:1]), "tone compare not half the period")

endmodule

bind melody_note_sequencer_core msq_checker u_msq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_play_state      (rsp_if.play_state),
   .rsp_song_select     (rsp_if.song_select),
   .rsp_note_pos        (rsp_if.note_pos),
   .rsp_tone_period     (rsp_if.tone_period),
   .rsp_tone_compare    (rsp_if.tone_compare),
   .rsp_display_refresh (rsp_if.display_refresh)
);

// ----- dv/melody_note_sequencer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody note sequencer core testbench
// Loads songs into the note store, selects and plays them with random pauses,
// stray keys and noise, under several register settings. A local player model
// predicts the status after every request; each response is compared with it.
// ----------------------------------------------------------------------------
module melody_note_sequencer_core_tb;
   import msq_pkg::*;

   localparam int NOTES         = NOTES_PER_SONG_DEF;
   localparam int STORE_DEPTH   = SONG_SLOTS_DEF * NOTES_PER_SONG_DEF;
   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 40;

   localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;
   // a key with no function in any state while song_count stays below 10
   localparam logic [KEY_W-1:0]  DEAD_KEY  = 4'd12;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
      logic [SONG_W-1:0] load_song;
      logic [POS_W-1:0]  load_position;
      logic [FREQ_W-1:0] load_freq;
      logic [DUR_W-1:0]  load_duration;
      logic              load_last;
   } seq_item_type;

   typedef struct packed {
      play_state_type       play_state;
      logic [SONG_W-1:0]    song_select;
      logic [POS_W-1:0]     note_pos;
      logic [PERIOD_W-1:0]  tone_period;
      logic [COMPARE_W-1:0] tone_compare;
      logic                 display_refresh;
   } player_status_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   msq_req_if req_if();
   msq_rsp_if rsp_if();

   melody_note_sequencer_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // player model
   logic [COUNT_W-1:0]   cfg_song_count;
   logic [TCLK_W-1:0]    cfg_tone_clock;
   logic [GATE_W-1:0]    cfg_gate_percent;
   play_state_type       pl_state;
   logic [SONG_W-1:0]    pl_song;
   logic [POS_W-1:0]     pl_note;
   logic [TICK_W-1:0]    pl_ticks;
   logic [PERIOD_W-1:0]  pl_period;
   logic [COMPARE_W-1:0] pl_compare;
   note_type             note_mem [STORE_DEPTH];
   bit                   note_written [STORE_DEPTH];

   player_status_type status_queue[$];
   int fail_count;
   int effective_items;
   int sent_count;
   int burst_left;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic note_type note_at(logic [SONG_W-1:0] song, logic [POS_W-1:0] pos);
      return note_mem[int'(song) * NOTES + int'(pos)];
   endfunction

   function automatic void set_tone(logic [FREQ_W-1:0] freq);
      int unsigned quo;
      if (freq == '0) begin
         pl_compare = '0;
      end else begin
         quo = cfg_tone_clock / freq;
         if (quo == 0)
            pl_period = '0;
         else if (quo - 1 > 65535)
            pl_period = '1;
         else
            pl_period = PERIOD_W'(quo - 1);
         pl_compare = COMPARE_W'(pl_period >> 1);
      end
   endfunction

   function automatic player_status_type advance_player(seq_item_type it);
      player_status_type st;
      note_type          nt;
      int unsigned       gate_tick;
      logic              refresh;
      int                idx;
      refresh = 1'b0;
      case (it.mode)
         MODE_LOAD: begin
            idx = int'(it.load_song) * NOTES + int'(it.load_position);
            note_mem[idx] = '{last: it.load_last, duration: it.load_duration,
                              freq: it.load_freq};
            note_written[idx] = 1'b1;
         end
         MODE_KEY: begin
            case (pl_state)
               PS_SELECT: begin
                  if (it.key >= 1 && it.key <= cfg_song_count) begin
                     pl_song = SONG_W'(it.key - 4'd1);
                  end else if (it.key == START_KEY) begin
                     pl_note  = '0;
                     pl_ticks = '0;
                     pl_state = PS_PLAY;
                     set_tone(note_at(pl_song, '0).freq);
                  end
               end
               PS_PLAY: begin
                  if (it.key == START_KEY) begin
                     pl_state   = PS_PAUSE;
                     pl_compare = '0;
                  end
               end
               default: begin
                  if (it.key == START_KEY) begin
                     pl_state = PS_PLAY;
                     set_tone(note_at(pl_song, pl_note).freq);
                  end
               end
            endcase
            refresh = 1'b1;
         end
         MODE_TICK: begin
            if (pl_state == PS_PLAY) begin
               nt = note_at(pl_song, pl_note);
               gate_tick = (32'(nt.duration) * 32'(cfg_gate_percent)) / GATE_DIV;
               pl_ticks = pl_ticks + 1'b1;
               if (pl_ticks == gate_tick)
                  pl_compare = '0;
               if (pl_ticks >= nt.duration) begin
                  pl_ticks = '0;
                  if (nt.last || pl_note == NOTES - 1) begin
                     pl_note  = '0;
                     pl_state = PS_SELECT;
                     refresh  = 1'b1;
                  end else begin
                     pl_note = pl_note + 1'b1;
                     set_tone(note_at(pl_song, pl_note).freq);
                  end
               end
            end
         end
         default: ;
      endcase
      st.play_state      = pl_state;
      st.song_select     = pl_song;
      st.note_pos        = pl_note;
      st.tone_period     = pl_period;
      st.tone_compare    = pl_compare;
      st.display_refresh = refresh;
      return st;
   endfunction

   // true when playback from position 'from' only meets written notes,
   // with one entry optionally replaced by a pending load
   function automatic bit path_written(logic [SONG_W-1:0] song, int from, int ovr_pos,
                                       note_type ovr);
      for (int p = from; p < NOTES; p++) begin
         note_type n;
         bit       w;
         if (p == ovr_pos) begin
            n = ovr;
            w = 1'b1;
         end else begin
            n = note_mem[int'(song) * NOTES + p];
            w = note_written[int'(song) * NOTES + p];
         end
         if (!w)
            return 1'b0;
         if (n.last)
            return 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic seq_item_type junk_item(logic [MODE_W-1:0] mode);
      seq_item_type it;
      it.mode          = mode;
      it.key           = KEY_W'($urandom_range(0, 15));
      it.load_song     = SONG_W'($urandom_range(0, 15));
      it.load_position = POS_W'($urandom_range(0, 31));
      it.load_freq     = FREQ_W'($urandom_range(0, 4095));
      it.load_duration = DUR_W'($urandom_range(0, 255));
      it.load_last     = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic logic [FREQ_W-1:0] rand_freq();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2)
         return '0;
      else if (pick == 2)
         return FREQ_W'($urandom_range(1, 15));
      else if (pick == 3)
         return '1;
      else
         return FREQ_W'($urandom_range(1, 4095));
   endfunction

   function automatic logic [DUR_W-1:0] rand_dur();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return DUR_W'($urandom_range(0, 5));
      else if (pick < 98)
         return DUR_W'($urandom_range(6, 30));
      else
         return DUR_W'($urandom_range(200, 255));
   endfunction

   task automatic send_item(seq_item_type it);
      bit counts;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         // leave some long stretches with back-to-back transfers
         if ((sent_count % 300) >= 60) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid         = 1'b1;
      req_if.mode          = it.mode;
      req_if.key           = it.key;
      req_if.load_song     = it.load_song;
      req_if.load_position = it.load_position;
      req_if.load_freq     = it.load_freq;
      req_if.load_duration = it.load_duration;
      req_if.load_last     = it.load_last;
      do @(posedge clock); while (!req_if.ready);
      counts = (it.mode == MODE_LOAD) || (it.mode == MODE_KEY) ||
               (it.mode == MODE_TICK && pl_state == PS_PLAY);
      if (counts)
         effective_items++;
      sent_count++;
      status_queue.push_back(advance_player(it));
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_item(junk_item(MODE_TICK));
   endtask

   task automatic send_key(logic [KEY_W-1:0] k);
      seq_item_type it;
      // never start a song whose notes are not all in the store
      if (k == START_KEY && pl_state == PS_SELECT && !path_written(pl_song, 0, -1, '0))
         k = DEAD_KEY;
      it = junk_item(MODE_KEY);
      it.key = k;
      send_item(it);
   endtask

   task automatic send_load(logic [SONG_W-1:0] song, logic [POS_W-1:0] pos,
                            logic [FREQ_W-1:0] freq, logic [DUR_W-1:0] dur, logic last);
      seq_item_type it;
      note_type     nt;
      nt = '{last: last, duration: dur, freq: freq};
      // hold the rest of the song in play on written notes
      if (pl_state != PS_SELECT && song == pl_song &&
          !path_written(song, int'(pl_note), int'(pos), nt))
         nt.last = 1'b1;
      it = junk_item(MODE_LOAD);
      it.load_song     = song;
      it.load_position = pos;
      it.load_freq     = nt.freq;
      it.load_duration = nt.duration;
      it.load_last     = nt.last;
      send_item(it);
   endtask

   task automatic send_random_load(logic [SONG_W-1:0] song);
      send_load(song, POS_W'($urandom_range(0, 31)), rand_freq(), rand_dur(),
                1'($urandom_range(0, 1)));
   endtask

   task automatic drain();
      req_if.valid = 1'b0;
      while (status_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         CSR_SONG_COUNT:   cfg_song_count   = data[COUNT_W-1:0];
         CSR_TONE_CLOCK:   cfg_tone_clock   = data[TCLK_W-1:0];
         CSR_GATE_PERCENT: cfg_gate_percent = data[GATE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(int songs, int tclk, int gate_pct);
      drain();
      write_reg(CSR_SONG_COUNT, CSR_DATA_W'(songs));
      write_reg(CSR_TONE_CLOCK, CSR_DATA_W'(tclk));
      write_reg(CSR_GATE_PERCENT, CSR_DATA_W'(gate_pct));
   endtask

   // play on until the song ends, with pauses, stray keys and loads in between
   task automatic finish_playback();
      int pick;
      while (pl_state != PS_SELECT) begin
         pick = $urandom_range(0, 99);
         if (pl_state == PS_PAUSE) begin
            if (pick < 40)
               send_key(START_KEY);
            else if (pick < 60)
               send_tick();
            else if (pick < 80)
               send_key(KEY_W'($urandom_range(0, 15)));
            else
               send_random_load(pick < 90 ? pl_song : SONG_W'($urandom_range(0, 15)));
         end else begin
            if (pick < 5)
               send_key(START_KEY);
            else if (pick < 9)
               send_key(KEY_W'($urandom_range(0, 15)));
            else if (pick < 13)
               send_random_load(pick < 11 ? pl_song : SONG_W'($urandom_range(0, 15)));
            else
               send_tick();
         end
      end
   endtask

   task automatic play_song();
      int  len;
      bit  full;
      logic [SONG_W-1:0] song;
      finish_playback();
      if (cfg_song_count == 0)
         song = pl_song;
      else
         song = SONG_W'($urandom_range(0, int'(cfg_song_count) - 1));
      // a song with no last flag runs to the last position of its slot
      full = ($urandom_range(0, 9) == 0);
      if (full)
         len = NOTES;
      else if ($urandom_range(0, 3) == 0)
         len = $urandom_range(1, NOTES);
      else
         len = $urandom_range(1, 5);
      for (int p = 0; p < len; p++) begin
         if (full)
            send_load(song, POS_W'(p), rand_freq(), DUR_W'($urandom_range(0, 2)), 1'b0);
         else
            send_load(song, POS_W'(p), rand_freq(), rand_dur(), p == len - 1);
      end
      if ($urandom_range(0, 3) == 0)
         send_key(KEY_W'($urandom_range(0, 15)));
      if (cfg_song_count != 0)
         send_key(KEY_W'(song + 1));
      send_key(START_KEY);
      finish_playback();
   endtask

   task automatic run_random(int count);
      int target;
      target = effective_items + count;
      while (effective_items < target) begin
         if ($urandom_range(0, 9) < 6) begin
            play_song();
         end else begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 9))
                  0, 1, 2: send_tick();
                  3, 4:    send_key($urandom_range(0, 2) == 0 ? START_KEY :
                                    KEY_W'($urandom_range(0, 15)));
                  5, 6, 7, 8: send_random_load(SONG_W'($urandom_range(0, 15)));
                  default: send_item(junk_item(MODE_IDLE));
               endcase
            end
         end
      end
   endtask

   // defaults: rest, saturated period, zero duration, pause and resume, stray keys
   task automatic test_directed_playback();
      send_load(4'd0, 5'd0, 12'd1, 8'd2, 1'b0);
      send_load(4'd0, 5'd1, 12'd0, 8'd0, 1'b0);
      send_load(4'd0, 5'd2, 12'd4095, 8'd3, 1'b1);
      send_load(4'd15, 5'd31, 12'd4095, 8'd255, 1'b1);
      send_load(4'd14, 5'd0, 12'd0, 8'd0, 1'b0);
      send_key(4'd0);
      send_key(4'd15);
      send_key(4'd9);
      send_key(4'd1);
      send_item(junk_item(MODE_IDLE));
      send_tick();
      send_key(START_KEY);
      send_tick();
      send_tick();
      send_tick();
      send_key(START_KEY);
      send_key(4'd5);
      send_tick();
      send_key(START_KEY);
      send_key(4'd3);
      repeat (3) send_tick();
   endtask

   task automatic test_config_corners();
      apply_settings(9, 1000000, 100);
      run_random(80);
      apply_settings(1, 1, 0);
      run_random(80);
      apply_settings(5, 0, 127);
      run_random(80);
      apply_settings(0, 4000, 50);
      run_random(80);
      apply_settings(9, 250000, 85);
      run_random(80);
   endtask

   task automatic test_random_settings();
      repeat (4) begin
         apply_settings($urandom_range(1, 9),
                        $urandom_range(0, 1) ? $urandom_range(1, 1000000) :
                                               $urandom_range(1, 5000),
                        $urandom_range(0, 4) == 0 ? $urandom_range(101, 127) :
                                                    $urandom_range(0, 100));
         run_random(80);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      player_status_type exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (status_queue.size() == 0) begin
            $error("unexpected status transfer");
            fail_count++;
         end else begin
            exp = status_queue.pop_front();
            if (rsp_if.play_state !== exp.play_state) begin
               $error("play_state: expected %0d, got %0d", exp.play_state, rsp_if.play_state);
               fail_count++;
            end
            if (rsp_if.song_select !== exp.song_select) begin
               $error("song_select: expected %0d, got %0d", exp.song_select,
                      rsp_if.song_select);
               fail_count++;
            end
            if (rsp_if.note_pos !== exp.note_pos) begin
               $error("note_pos: expected %0d, got %0d", exp.note_pos, rsp_if.note_pos);
               fail_count++;
            end
            if (rsp_if.tone_period !== exp.tone_period) begin
               $error("tone_period: expected %0d, got %0d", exp.tone_period,
                      rsp_if.tone_period);
               fail_count++;
            end
            if (rsp_if.tone_compare !== exp.tone_compare) begin
               $error("tone_compare: expected %0d, got %0d", exp.tone_compare,
                      rsp_if.tone_compare);
               fail_count++;
            end
            if (rsp_if.display_refresh !== exp.display_refresh) begin
               $error("display_refresh: expected %0d, got %0d", exp.display_refresh,
                      rsp_if.display_refresh);
               fail_count++;
            end
         end
      end
   end

   // receiver stalls: open windows, random drops and occasional long holds
   initial begin
      int stall_left;
      int cyc;
      rsp_if.ready = 1'b0;
      stall_left = 0;
      cyc = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if ((cyc % 1024) < 150) begin
            rsp_if.ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 19) == 0) begin
            rsp_if.ready = 1'b0;
            stall_left = $urandom_range(1, 12);
         end else begin
            rsp_if.ready = ($urandom_range(0, 3) != 0);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("melody_note_sequencer_core_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset                = 1'b1;
      csr_write_en         = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.mode          = '0;
      req_if.key           = '0;
      req_if.load_song     = '0;
      req_if.load_position = '0;
      req_if.load_freq     = '0;
      req_if.load_duration = '0;
      req_if.load_last     = 1'b0;
      cfg_song_count       = SONG_COUNT_RST;
      cfg_tone_clock       = TONE_CLOCK_RST;
      cfg_gate_percent     = GATE_PERCENT_RST;
      pl_state             = PS_SELECT;
      pl_song              = '0;
      pl_note              = '0;
      pl_ticks             = '0;
      pl_period            = '0;
      pl_compare           = '0;
      fail_count           = 0;
      effective_items      = 0;
      sent_count           = 0;
      burst_left           = 0;
      idle_cycles          = 0;
      foreach (note_written[i]) begin
         note_written[i] = 1'b0;
         note_mem[i]     = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_playback();
      test_config_corners();
      test_random_settings();

      req_if.valid = 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("melody_note_sequencer_core_tb: PASS");
      else
         $display("melody_note_sequencer_core_tb: FAIL");
      $finish;
   end

endmodule
